/* src/fletcher_bit_serial_checker_core_assert.svh */
// Assertion macros shared by the checker RTL.
// Needs no package; each use names its own clock and active-low reset.
`ifndef FLETCHER_BIT_SERIAL_CHECKER_CORE_ASSERT_SVH
`define FLETCHER_BIT_SERIAL_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FBSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fbsc assertion failed");

// Next-cycle implication, checked outside reset.
`define FBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fbsc assertion failed");

`endif

/* src/fbsc_pkg.sv */
// Shared widths, types and helper functions of the Fletcher bit-serial checker.
// Used by fbsc_modred and fletcher_bit_serial_checker_core.
package fbsc_pkg;

    localparam int MAX_BLOCK = 16;
    localparam int K_W       = 5;
    localparam int SUM_W     = 16;
    localparam int TAIL_W    = 32;
    localparam int CNT_W     = 6;
    localparam int FILL_W    = 5;
    localparam int RED_W     = SUM_W + 1;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 72;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'b0001,
        ST_RED_FIRST  = 4'b0010,
        ST_RED_SECOND = 4'b0100,
        ST_FINISH     = 4'b1000
    } state_t;

    // Request to the modular reduction unit.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] op_a;
        logic [SUM_W-1:0] op_b;
        logic [K_W-1:0]   k;
    } modred_req_t;

    // Answer from the modular reduction unit.
    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] result;
    } modred_rsp_t;

    // Block sizes of zero act as one, and sizes above the maximum as the maximum.
    function automatic logic [K_W-1:0] eff_block(input logic [K_W-1:0] raw);
        logic [K_W-1:0] k;
        if (raw == '0) begin
            k = K_W'(1);
        end else if (raw > K_W'(MAX_BLOCK)) begin
            k = K_W'(MAX_BLOCK);
        end else begin
            k = raw;
        end
        return k;
    endfunction

endpackage

/* src/fletcher_bit_serial_checker_core.sv */
// Top level of the Fletcher bit-serial checker: frame shift registers, sequencer, output item.
// Depends on fbsc_pkg, fbsc_modred and the assertion macro header.
//
// Frame bits enter one per item, most significant first, with tlast on the final bit. The
// newest 2k bits sit in a shift register and each older bit shifts into a block register.
// An item that completes a k-bit block runs two reductions modulo 2^k-1 in one shared
// fold unit, one after the other, during which tready is low. While k stays fixed each
// reduction needs at most one fold; after the block size has shrunk mid-frame a reduction
// may need up to about 17 folds. The final item of a frame passes through a finish state
// that loads the result item, waiting while the previous result item has not yet been
// taken; the frame state is then cleared. The user must write the block size through
// cfg_we/cfg_wdata only while no frame work is pending; the block itself does not enforce
// this.
`include "fletcher_bit_serial_checker_core_assert.svh"

module fletcher_bit_serial_checker_core
    import fbsc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [K_W-1:0]      cfg_wdata,       // block_bits
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,         // [0] frame_bit, rest zero
    input  logic                s_tlast,         // frame_end
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,         // [0] match, [32:1] computed_sum,
                                                 // [64:33] received_sum, rest zero
    output logic                m_tuser          // too_short
);

    logic [K_W-1:0]      block_bits_reg, block_bits_next;
    state_t              state_reg, state_next;
    logic [TAIL_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]    seen_reg, seen_next;
    logic [SUM_W-1:0]    accum_reg, accum_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [SUM_W-1:0]    first_reg, first_next;
    logic [SUM_W-1:0]    second_reg, second_next;
    logic                end_reg, end_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_user_reg, m_user_next;

    logic [K_W-1:0]      k;
    logic [CNT_W-1:0]    cw;
    logic [CNT_W-1:0]    seen_cap;
    logic [CNT_W-1:0]    seen_inc;
    logic [TAIL_W-1:0]   tail_mask;
    logic                old_bit;
    logic [SUM_W-1:0]    accum_shift;
    logic [FILL_W-1:0]   fill_inc;
    logic                in_accept;
    logic                block_done;
    logic                out_free;
    logic                short_frame;
    logic [TAIL_W-1:0]   computed;
    modred_req_t         red_req;
    modred_rsp_t         red_rsp;

    fbsc_modred u_modred (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (red_req),
        .rsp     (red_rsp)
    );

    assign k         = eff_block(block_bits_reg);
    assign cw        = {CNT_W'(k)} << 1;
    assign seen_cap  = cw + CNT_W'(1);
    assign seen_inc  = seen_reg + CNT_W'(1);
    assign tail_mask = TAIL_W'(({1'b0, {TAIL_W{1'b1}}} >> (CNT_W'(TAIL_W) - cw)));
    assign old_bit   = tail_reg[K_W'(cw - CNT_W'(1))];
    assign accum_shift = {accum_reg[SUM_W-2:0], old_bit};
    assign fill_inc  = fill_reg + FILL_W'(1);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    // Once the checksum window is full, the bit leaving it is a data bit.
    assign block_done = (seen_reg >= cw) && (fill_inc >= FILL_W'(k));
    assign out_free   = !m_valid_reg || m_tready;
    assign short_frame = (seen_reg <= cw);
    assign computed   = (TAIL_W'(second_reg) << k) | TAIL_W'(first_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        block_bits_next = cfg_we ? cfg_wdata : block_bits_reg;
        state_next   = state_reg;
        tail_next    = tail_reg;
        seen_next    = seen_reg;
        accum_next   = accum_reg;
        fill_next    = fill_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        end_next     = end_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        red_req.start = 1'b0;
        red_req.op_a  = first_reg;
        red_req.op_b  = accum_shift;
        red_req.k     = k;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    end_next  = s_tlast;
                    tail_next = {tail_reg[TAIL_W-2:0], s_tdata[0]} & tail_mask;
                    seen_next = (seen_inc > seen_cap) ? seen_cap : seen_inc;
                    if (seen_reg >= cw) begin
                        if (block_done) begin
                            accum_next    = '0;
                            fill_next     = '0;
                            red_req.start = 1'b1;
                            state_next    = ST_RED_FIRST;
                        end else begin
                            accum_next = accum_shift;
                            fill_next  = fill_inc;
                        end
                    end
                    if (!block_done && s_tlast) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_RED_FIRST: begin
                red_req.op_a = second_reg;
                red_req.op_b = red_rsp.result;
                if (red_rsp.done) begin
                    first_next    = red_rsp.result;
                    red_req.start = 1'b1;
                    state_next    = ST_RED_SECOND;
                end
            end
            ST_RED_SECOND: begin
                if (red_rsp.done) begin
                    second_next = red_rsp.result;
                    state_next  = end_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = short_frame;
                    if (short_frame) begin
                        m_data_next = '0;
                    end else begin
                        m_data_next = {7'b0, tail_reg, computed, computed == tail_reg};
                    end
                    tail_next   = '0;
                    seen_next   = '0;
                    accum_next  = '0;
                    fill_next   = '0;
                    first_next  = '0;
                    second_next = '0;
                    end_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_bits_reg <= K_W'(8);
            state_reg      <= ST_IDLE;
            tail_reg       <= '0;
            seen_reg       <= '0;
            accum_reg      <= '0;
            fill_reg       <= '0;
            first_reg      <= '0;
            second_reg     <= '0;
            end_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            block_bits_reg <= block_bits_next;
            state_reg      <= state_next;
            tail_reg       <= tail_next;
            seen_reg       <= seen_next;
            accum_reg      <= accum_next;
            fill_reg       <= fill_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            end_reg        <= end_next;
            m_valid_reg    <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    `FBSC_ASSERT_NOW(a_done_in_reduce, aclk, aresetn, red_rsp.done, (state_reg == ST_RED_FIRST) || (state_reg == ST_RED_SECOND))
    `FBSC_ASSERT_NOW(a_seen_capped, aclk, aresetn, 1'b1, seen_reg <= CNT_W'(2 * MAX_BLOCK + 1))
    `FBSC_ASSERT_NOW(a_short_zero, aclk, aresetn, m_valid_reg && m_user_reg, m_data_reg == '0)
    `FBSC_ASSERT_NEXT(a_clear_after_out, aclk, aresetn, (state_reg == ST_FINISH) && out_free, (seen_reg == '0) && m_valid_reg)
    `FBSC_ASSERT_NEXT(a_block_starts_red, aclk, aresetn, in_accept && block_done, state_reg == ST_RED_FIRST)

endmodule

/* src/fbsc_modred.sv */
// Iterative reduction of a sum of two 16-bit values modulo 2^k-1.
// Depends on fbsc_pkg for the request and answer structs.
module fbsc_modred
    import fbsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  modred_req_t req,
    output modred_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic [RED_W-1:0] acc_reg, acc_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [RED_W-1:0] high_part;
    logic [RED_W-1:0] low_mask;
    logic             settled;

    // Since 2^k is 1 modulo 2^k-1, the part above bit k folds back onto the low part.
    assign high_part = acc_reg >> k_reg;
    assign low_mask  = (RED_W'(1) << k_reg) - RED_W'(1);
    assign settled   = (high_part == '0);

    assign rsp.done   = busy_reg && settled;
    assign rsp.result = (acc_reg == low_mask) ? '0 : acc_reg[SUM_W-1:0];

    always_comb begin
        busy_next = busy_reg;
        acc_next  = acc_reg;
        k_next    = k_reg;
        if (req.start) begin
            busy_next = 1'b1;
            acc_next  = RED_W'(req.op_a) + RED_W'(req.op_b);
            k_next    = req.k;
        end else if (busy_reg) begin
            if (settled) begin
                busy_next = 1'b0;
            end else begin
                acc_next = (acc_reg & low_mask) + high_part;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        acc_reg <= acc_next;
        k_reg   <= k_next;
    end

endmodule
